### sv/scl_pkg.sv
`default_nettype none
package scl_pkg;

    localparam int TAPS             = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W   = $clog2(TAPS + 1);
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_W  = $clog2(QUARTER + 1);

    // datapath widths
    localparam int ACC_W = 40 + TAP_W + 1;
    localparam int E_W   = ACC_W - 19;
    localparam int GP_W  = E_W + 33;
    localparam int G_W   = GP_W - 16;
    localparam int D_W   = G_W + 16;
    localparam int DL_W  = D_W - 25;
    localparam int S_W   = DL_W + 1;

    localparam logic [15:0] ONE_PERCENT_Q16 = 16'd655;

    typedef enum logic [2:0] {
        REG_STEP_SIZE   = 3'd0,
        REG_PHASE_STEP  = 3'd1,
        REG_ALPHA       = 3'd2,
        REG_THRESHOLD   = 3'd3,
        REG_LEAK        = 3'd4,
        REG_LIMIT       = 3'd5,
        REG_TAPS        = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] step_size;
        logic [15:0] phase_step;
        logic [15:0] energy_alpha;
        logic [30:0] quiet_threshold;
        logic [15:0] leak_factor;
        logic [22:0] coeff_limit;
        logic [4:0]  taps_in_use;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic en1;
        logic en2;
        logic en3;
        logic fil_s;
        logic fil_m;
        logic fil_a;
        logic err1;
        logic err2;
        logic err3;
        logic up_s;
        logic up_m;
        logic up_w;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic last_tap;
        logic no_taps;
        logic out_free;
    } status_t;

    typedef logic [15:0] qsine_t [0:QUARTER];

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned SIN_C1  = 64'd1686629713;
    localparam longint unsigned SIN_C3  = 64'd693598670;
    localparam longint unsigned SIN_C5  = 64'd85569306;
    localparam longint unsigned SIN_C7  = 64'd5026995;
    localparam longint unsigned SIN_C9  = 64'd172272;

    function automatic longint unsigned quarter_sine(longint unsigned u);
        longint unsigned u2;
        longint unsigned r;
        u2 = (u * u) >> 30;
        r  = SIN_C9;
        r  = SIN_C7 - ((u2 * r) >> 30);
        r  = SIN_C5 - ((u2 * r) >> 30);
        r  = SIN_C3 - ((u2 * r) >> 30);
        r  = SIN_C1 - ((u2 * r) >> 30);
        return (u * r) >> 30;
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t t;
        longint unsigned u;
        longint unsigned s;
        for (int j = 0; j <= QUARTER; j++) begin
            u = (longint'(j) * 4 * Q30_ONE) / SINE_TABLE_DEPTH;
            s = (quarter_sine(u) + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            t[j] = s[15:0];
        end
        return t;
    endfunction

    localparam qsine_t QSINE = build_qsine();

endpackage
`default_nettype wire

### sv/scl_ctrl.sv
`default_nettype none
module scl_ctrl
    import scl_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_EN1   = 14'b00000000000010,
        ST_EN2   = 14'b00000000000100,
        ST_EN3   = 14'b00000000001000,
        ST_FIL_S = 14'b00000000010000,
        ST_FIL_M = 14'b00000000100000,
        ST_FIL_A = 14'b00000001000000,
        ST_ERR1  = 14'b00000010000000,
        ST_ERR2  = 14'b00000100000000,
        ST_ERR3  = 14'b00001000000000,
        ST_UP_S  = 14'b00010000000000,
        ST_UP_M  = 14'b00100000000000,
        ST_UP_W  = 14'b01000000000000,
        ST_FIN   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_EN1;
            ST_EN1:   state_next = ST_EN2;
            ST_EN2:   state_next = ST_EN3;
            ST_EN3:   state_next = status.no_taps ? ST_ERR1 : ST_FIL_S;
            ST_FIL_S: state_next = ST_FIL_M;
            ST_FIL_M: state_next = ST_FIL_A;
            ST_FIL_A: state_next = status.last_tap ? ST_ERR1 : ST_FIL_S;
            ST_ERR1:  state_next = ST_ERR2;
            ST_ERR2:  state_next = ST_ERR3;
            ST_ERR3:  state_next = status.no_taps ? ST_FIN : ST_UP_S;
            ST_UP_S:  state_next = ST_UP_M;
            ST_UP_M:  state_next = ST_UP_W;
            ST_UP_W:  state_next = status.last_tap ? ST_FIN : ST_UP_S;
            ST_FIN:   if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.en1   = (state_reg == ST_EN1);
    assign cmd.en2   = (state_reg == ST_EN2);
    assign cmd.en3   = (state_reg == ST_EN3);
    assign cmd.fil_s = (state_reg == ST_FIL_S);
    assign cmd.fil_m = (state_reg == ST_FIL_M);
    assign cmd.fil_a = (state_reg == ST_FIL_A);
    assign cmd.err1  = (state_reg == ST_ERR1);
    assign cmd.err2  = (state_reg == ST_ERR2);
    assign cmd.err3  = (state_reg == ST_ERR3);
    assign cmd.up_s  = (state_reg == ST_UP_S);
    assign cmd.up_m  = (state_reg == ST_UP_M);
    assign cmd.up_w  = (state_reg == ST_UP_W);
    assign cmd.fin   = (state_reg == ST_FIN);

endmodule
`default_nettype wire

### sv/scl_datapath.sv
`default_nettype none
module scl_datapath
    import scl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire cmd_t        cmd,
    output status_t          status,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic [7:0]       m_tuser,
    output logic             m_tlast
);

    logic signed [15:0]    x_reg;
    logic                  last_reg;
    logic [30:0]           x2_reg;
    logic [47:0]           pa_reg;
    logic [47:0]           pb_reg;
    logic [31:0]           energy_reg;
    logic                  silent_reg;
    logic [15:0]           phase_reg;
    logic [15:0]           ph_k_reg;
    logic [TAP_W-1:0]      tap_reg;
    logic signed [23:0]    coef_reg [TAPS];
    logic signed [15:0]    sine_reg;
    logic signed [39:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [E_W-1:0] err_reg;
    logic [32:0]           mu_reg;
    logic signed [GP_W-1:0] gprod_reg;
    logic signed [G_W-1:0] g_reg;
    logic signed [40:0]    lprod_reg;
    logic signed [D_W-1:0] dprod_reg;
    logic signed [23:0]    lk_reg;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;
    logic                  out_silent_reg;
    logic                  out_last_reg;

    // tap count
    logic [CNT_W-1:0] n_taps;
    assign n_taps = ({27'd0, cfg.taps_in_use} > TAPS) ? CNT_W'(TAPS)
                                                      : CNT_W'(cfg.taps_in_use);
    assign status.no_taps  = (n_taps == '0);
    assign status.last_tap = (CNT_W'(tap_reg) == n_taps - CNT_W'(1));
    assign status.out_free = !out_valid_reg || m_tready;

    // sine reference from quarter-wave table
    logic [IDX_W-1:0]  idx;
    logic [1:0]        quad;
    logic [QIDX_W-1:0] qj;
    logic signed [15:0] qval;
    logic signed [15:0] sine_val;
    assign idx  = ph_k_reg[15 -: IDX_W];
    assign quad = idx[IDX_W-1 -: 2];
    assign qj   = quad[0] ? (QIDX_W'(QUARTER) - QIDX_W'(idx[IDX_W-3:0]))
                          : QIDX_W'(idx[IDX_W-3:0]);
    assign qval = $signed(QSINE[qj]);
    assign sine_val = quad[1] ? -qval : qval;

    // energy
    logic signed [31:0] sq;
    logic [48:0]        esum;
    logic [31:0]        energy_new;
    assign sq         = 32'(x_reg) * 32'(x_reg);
    assign esum       = 49'(pa_reg) + 49'(pb_reg) + 49'd32768;
    assign energy_new = esum[47:16];

    // error
    logic signed [ACC_W-1:0] ysum;
    logic signed [E_W-1:0]   err_new;
    logic signed [15:0]      sat;
    assign ysum    = acc_reg + ACC_W'(21'sh80000);
    assign err_new = E_W'(x_reg) - E_W'($signed(ysum[ACC_W-1:20]));
    assign sat = (err_reg > E_W'(32767)) ? 16'sh7fff :
                 (err_reg < -E_W'(32768)) ? 16'sh8000 : err_reg[15:0];

    logic signed [GP_W-1:0] gsum;
    assign gsum = gprod_reg + GP_W'(17'sh8000);

    // coefficient update
    logic signed [23:0]     coef_k;
    logic signed [40:0]     lsum;
    logic signed [D_W-1:0]  dsum;
    logic signed [S_W-1:0]  csum;
    logic signed [S_W-1:0]  lim;
    logic signed [23:0]     c_clip;
    assign coef_k = coef_reg[tap_reg];
    assign lsum   = lprod_reg + 41'sh8000;
    assign dsum   = dprod_reg + D_W'(26'sh1000000);
    assign csum   = S_W'(lk_reg) + S_W'($signed(dsum[D_W-1:25]));
    assign lim    = S_W'($signed({1'b0, cfg.coeff_limit}));
    assign c_clip = (csum > lim) ? lim[23:0] : (csum < -lim) ? -lim[23:0] : csum[23:0];

    logic fin_go;
    assign fin_go = cmd.fin && status.out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= $signed(s_tdata);
            last_reg <= s_tlast;
        end
        if (cmd.en1) begin
            x2_reg <= sq[30:0];
            pa_reg <= 48'(cfg.energy_alpha) * 48'(energy_reg);
        end
        if (cmd.en2) begin
            pb_reg <= 48'(17'h10000 - {1'b0, cfg.energy_alpha}) * 48'(x2_reg);
        end
        if (cmd.en3 || cmd.err3) begin
            tap_reg  <= '0;
            ph_k_reg <= phase_reg;
        end
        if (cmd.en3) begin
            silent_reg <= energy_new < {1'b0, cfg.quiet_threshold};
            acc_reg    <= '0;
        end
        if (cmd.fil_s || cmd.up_s) begin
            sine_reg <= sine_val;
        end
        if (cmd.up_s) begin
            lprod_reg <= 41'(coef_k) * 41'($signed({1'b0, cfg.leak_factor}));
        end
        if (cmd.fil_m) begin
            prod_reg <= 40'(coef_k) * 40'(sine_reg);
        end
        if (cmd.fil_a) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.fil_a || cmd.up_w) begin
            tap_reg  <= tap_reg + TAP_W'(1);
            ph_k_reg <= ph_k_reg - cfg.phase_step;
        end
        if (cmd.err1) begin
            err_reg <= err_new;
            mu_reg  <= silent_reg ? 33'(cfg.step_size) * 33'(ONE_PERCENT_Q16)
                                  : {1'b0, cfg.step_size, 16'd0};
        end
        if (cmd.err2) begin
            gprod_reg <= GP_W'(err_reg) * GP_W'($signed(mu_reg));
        end
        if (cmd.err3) begin
            g_reg <= $signed(gsum[GP_W-1:16]);
        end
        if (cmd.up_m) begin
            dprod_reg <= D_W'(g_reg) * D_W'(sine_reg);
            lk_reg    <= silent_reg ? lsum[39:16] : coef_k;
        end
        if (cmd.up_w) begin
            coef_reg[tap_reg] <= c_clip;
        end
        if (fin_go) begin
            out_data_reg   <= sat;
            out_silent_reg <= silent_reg;
            out_last_reg   <= last_reg;
        end
        if (!aresetn) begin
            energy_reg    <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                coef_reg[k] <= '0;
            end
        end else begin
            if (cmd.en3) begin
                energy_reg <= energy_new;
            end
            if (fin_go) begin
                phase_reg     <= phase_reg + cfg.phase_step;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {7'd0, out_silent_reg};
    assign m_tlast  = out_last_reg;

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fil_a || cmd.up_w) |-> (CNT_W'(tap_reg) < n_taps))
        else $error("tap index beyond active taps");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.up_w |-> (S_W'(c_clip) <= lim && S_W'(c_clip) >= -lim))
        else $error("coefficient outside limit");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> (m_tvalid && $changed(phase_reg) || cfg.phase_step == 16'd0))
        else $error("result not presented after finish");

endmodule
`default_nettype wire

### sv/sine_reference_lms_canceller_core.sv
// sinusoidal interference canceller, lms adapted
// input channel s_*: one signed q1.15 sample per item, tlast passed through
// result channel m_*: one cleaned sample per input item, tuser[0] flags silence,
// tlast copies the input tlast
// registers on the apb port: step_size, phase_step, energy_alpha,
// quiet_threshold, leak_factor, coeff_limit, taps_in_use at 4*i
// an item runs from accept through the energy update, a filter pass over the active
// taps, the error and gain and an update pass over those taps to the result: each tap
// passes twice through the sine table, a multiplier and the accumulate or coefficient
// write; the next item is accepted once the previous one's result is in the output
// register, also while that result still waits for m_tready
// a stalled receiver holds the result; the core then waits in its final step
// reset clears phase, energy, coefficients and loads register defaults
`default_nettype none
module sine_reference_lms_canceller_core
    import scl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // cleaned
    output logic [7:0]       m_tuser,   // is_silent
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size         <= 16'd328;
            cfg_reg.phase_step        <= 16'd68;
            cfg_reg.energy_alpha      <= 16'd65208;
            cfg_reg.quiet_threshold   <= 31'd1073742;
            cfg_reg.leak_factor       <= 16'd65470;
            cfg_reg.coeff_limit       <= 23'd2097152;
            cfg_reg.taps_in_use       <= 5'd16;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_STEP_SIZE:  cfg_reg.step_size         <= pwdata[15:0];
                REG_PHASE_STEP: cfg_reg.phase_step        <= pwdata[15:0];
                REG_ALPHA:      cfg_reg.energy_alpha      <= pwdata[15:0];
                REG_THRESHOLD:  cfg_reg.quiet_threshold   <= pwdata[30:0];
                REG_LEAK:       cfg_reg.leak_factor       <= pwdata[15:0];
                REG_LIMIT:      cfg_reg.coeff_limit       <= pwdata[22:0];
                REG_TAPS:       cfg_reg.taps_in_use       <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STEP_SIZE:  prdata = 32'(cfg_reg.step_size);
            REG_PHASE_STEP: prdata = 32'(cfg_reg.phase_step);
            REG_ALPHA:      prdata = 32'(cfg_reg.energy_alpha);
            REG_THRESHOLD:  prdata = 32'(cfg_reg.quiet_threshold);
            REG_LEAK:       prdata = 32'(cfg_reg.leak_factor);
            REG_LIMIT:      prdata = 32'(cfg_reg.coeff_limit);
            REG_TAPS:       prdata = 32'(cfg_reg.taps_in_use);
            default:        prdata = 32'd0;
        endcase
    end

    scl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scl_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

### sim/tb_sine_reference_lms_canceller_core.sv
`timescale 1ns / 100ps
module tb_sine_reference_lms_canceller_core;
    import scl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 150;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } sample_item_t;

    typedef struct packed {
        logic [15:0] cleaned;
        logic        silent;
        logic        block_end;
    } cleaned_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // sample
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // cleaned
    logic [7:0]  m_tuser;        // is_silent, then zeros
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sine_reference_lms_canceller_core dut (.*);

    always #1 aclk = ~aclk;

    sample_item_t  pending_samples[$];
    cleaned_item_t expected_cleaned[$];
    int            fail_count = 0;
    bit            bursty = 1'b1;
    int            src_gap = 0;
    int            sink_gap = 0;
    int            quiet_cycles = 0;

    // canceller shadow state
    cfg_t          cfg;
    logic [15:0]   phase_acc;
    logic [31:0]   energy;
    longint        coef[TAPS];

    function automatic longint unsigned poly_quarter(longint unsigned u);
        longint unsigned u2, r;
        u2 = (u * u) >> 30;
        r = 64'd172272;
        r = 64'd5026995 - ((u2 * r) >> 30);
        r = 64'd85569306 - ((u2 * r) >> 30);
        r = 64'd693598670 - ((u2 * r) >> 30);
        r = 64'd1686629713 - ((u2 * r) >> 30);
        return (u * r) >> 30;
    endfunction

    function automatic longint sine_q15(logic [15:0] ph);
        int unsigned idx, q, rem, num;
        longint unsigned s;
        idx = (int'(ph) * SINE_TABLE_DEPTH) >> 16;
        q = (idx * 4) / SINE_TABLE_DEPTH;
        rem = idx * 4 - q * SINE_TABLE_DEPTH;
        num = q[0] ? SINE_TABLE_DEPTH - rem : rem;
        s = (poly_quarter((longint'(num) << 30) / SINE_TABLE_DEPTH) + 16384) >> 15;
        if (s > 32767) begin
            s = 32767;
        end
        return q[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint round_down_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    task automatic cancel_sample(sample_item_t it);
        longint x, y, e, g, mu, c, lim;
        longint unsigned acc;
        logic [15:0] p;
        bit silent;
        int n;
        cleaned_item_t r;
        x = longint'($signed(it.sample));
        acc = longint'(cfg.energy_alpha) * longint'(energy)
            + (65536 - longint'(cfg.energy_alpha)) * longint'(x * x) + 32768;
        energy = acc[47:16];
        silent = energy < {1'b0, cfg.quiet_threshold};
        mu = silent ? longint'(cfg.step_size) * 655 : longint'(cfg.step_size) * 65536;
        n = (cfg.taps_in_use > TAPS) ? TAPS : int'(cfg.taps_in_use);
        lim = longint'(cfg.coeff_limit);
        y = 0;
        for (int k = 0; k < n; k++) begin
            p = phase_acc - 16'(k * cfg.phase_step);
            y += coef[k] * sine_q15(p);
        end
        y = round_down_shift(y, 20);
        e = x - y;
        g = round_down_shift(2 * mu * e, 17);
        for (int k = 0; k < n; k++) begin
            p = phase_acc - 16'(k * cfg.phase_step);
            c = coef[k];
            if (silent) begin
                c = round_down_shift(c * longint'(cfg.leak_factor), 16);
            end
            c += round_down_shift(g * sine_q15(p), 25);
            if (c > lim) begin
                c = lim;
            end else if (c < -lim) begin
                c = -lim;
            end
            coef[k] = c;
        end
        phase_acc = phase_acc + cfg.phase_step;
        r.cleaned = (e > 32767) ? 16'h7fff : (e < -32768) ? 16'h8000 : e[15:0];
        r.silent = silent;
        r.block_end = it.last;
        expected_cleaned.push_back(r);
    endtask

    // source side
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cancel_sample('{s_tdata, s_tlast});
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    if (bursty && $urandom_range(0, 19) == 0) begin
                        src_gap <= $urandom_range(1, 18);
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tdata <= pending_samples[0].sample;
                        s_tlast <= pending_samples[0].last;
                        s_tvalid <= 1'b1;
                        void'(pending_samples.pop_front());
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        cleaned_item_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_cleaned.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected item cleaned=%h silent=%h last=%h",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_cleaned.pop_front();
                    if (m_tdata !== want.cleaned) begin
                        fail_count++;
                        $display("%0t: cleaned expected %h actual %h",
                                 $time, want.cleaned, m_tdata);
                    end
                    if (m_tuser !== {7'd0, want.silent}) begin
                        fail_count++;
                        $display("%0t: is_silent expected %h actual %h",
                                 $time, want.silent, m_tuser);
                    end
                    if (m_tlast !== want.block_end) begin
                        fail_count++;
                        $display("%0t: block_end expected %h actual %h",
                                 $time, want.block_end, m_tlast);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (bursty && $urandom_range(0, 24) == 0) begin
                sink_gap <= $urandom_range(1, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_sine_reference_lms_canceller_core failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(4 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STEP_SIZE:  cfg.step_size = value[15:0];
            REG_PHASE_STEP: cfg.phase_step = value[15:0];
            REG_ALPHA:      cfg.energy_alpha = value[15:0];
            REG_THRESHOLD:  cfg.quiet_threshold = value[30:0];
            REG_LEAK:       cfg.leak_factor = value[15:0];
            REG_LIMIT:      cfg.coeff_limit = value[22:0];
            REG_TAPS:       cfg.taps_in_use = value[4:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] mu, logic [15:0] dph, logic [15:0] alpha,
                             logic [30:0] thr, logic [15:0] leak, logic [22:0] lim,
                             logic [4:0] ntaps);
        write_reg(REG_STEP_SIZE, 32'(mu));
        write_reg(REG_PHASE_STEP, 32'(dph));
        write_reg(REG_ALPHA, 32'(alpha));
        write_reg(REG_THRESHOLD, 32'(thr));
        write_reg(REG_LEAK, 32'(leak));
        write_reg(REG_LIMIT, 32'(lim));
        write_reg(REG_TAPS, 32'(ntaps));
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_tvalid || expected_cleaned.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // tone plus noise, with quiet stretches and full-range items mixed in
    task automatic queue_random(int count);
        logic [15:0] tone_ph, tone_step;
        longint amp, v;
        int mode;
        tone_ph = 16'($urandom);
        tone_step = 16'($urandom_range(1, 4000));
        amp = $urandom_range(0, 30000);
        mode = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                mode = $urandom_range(0, 3);
            end
            tone_ph += tone_step;
            case (mode)
                0, 1:    v = (amp * sine_q15(tone_ph)) / 32768
                           + longint'($urandom_range(0, 2000)) - 1000;
                2:       v = longint'($urandom_range(0, 40)) - 20;
                default: v = longint'($urandom_range(0, 65535)) - 32768;
            endcase
            if (v > 32767) begin
                v = 32767;
            end else if (v < -32768) begin
                v = -32768;
            end
            pending_samples.push_back('{v[15:0], 1'($urandom_range(0, 7) == 0)});
        end
    endtask

    initial begin
        cfg = '{16'd328, 16'd68, 16'd65208, 31'd1073742, 16'd65470, 23'd2097152, 5'd16};
        phase_acc = '0;
        energy = '0;
        foreach (coef[k]) begin
            coef[k] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_all(16'd328, 16'd68, 16'd65208, 31'd1073742, 16'd65470, 23'd2097152, 5'd16);
        for (int i = 0; i < 18; i++) begin
            pending_samples.push_back('{16'($urandom), 1'(i % 3 == 2)});
        end
        pending_samples[0].sample = 16'h0000;
        pending_samples[1].sample = 16'h7fff;
        pending_samples[2].sample = 16'h8000;
        pending_samples[3].sample = 16'hffff;
        pending_samples[4].sample = 16'h0001;
        pending_samples[5].sample = 16'h5555;
        pending_samples[6].sample = 16'haaaa;
        wait_drained();

        // aggressive adaptation, never silent, wide limit
        write_all(16'hffff, 16'h1234, 16'h0000, 31'd0, 16'h0000, 23'h7fffff, 5'd16);
        for (int i = 0; i < 6; i++) begin
            pending_samples.push_back('{(i % 2) ? 16'h8000 : 16'h7fff, 1'b1});
        end
        wait_drained();

        // always silent, zero taps, zero limit
        write_all(16'h0000, 16'hffff, 16'hffff, 31'h7fffffff, 16'hffff, 23'd0, 5'd0);
        queue_random(80);
        wait_drained();

        // more taps than built, then random settings
        write_reg(REG_TAPS, 32'd20);
        write_reg(REG_LIMIT, 32'h7fffff);
        write_reg(REG_STEP_SIZE, 32'd2000);
        queue_random(120);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            write_all(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 6000)),
                      16'($urandom_range(60000, 65535)),
                      31'($urandom_range(0, 20000000)), 16'($urandom),
                      23'($urandom_range(0, 8388607)),
                      5'((ph == 3) ? 31 : $urandom_range(1, 16)));
            if (ph == 5) begin
                write_reg(REG_STEP_SIZE, 32'hffff);
                write_reg(REG_ALPHA, 32'($urandom));
            end
            queue_random(150);
            wait_drained();
        end

        bursty = 1'b0;
        write_all(16'd328, 16'd68, 16'd65208, 31'd1073742, 16'd65470, 23'd2097152, 5'd16);
        queue_random(200);
        wait_drained();

        if (fail_count == 0) begin
            $display("tb_sine_reference_lms_canceller_core passed");
        end else begin
            $display("tb_sine_reference_lms_canceller_core failed");
        end
        $finish;
    end

endmodule
